// ===== src/nspe_pkg.sv =====
package nspe_pkg;

    localparam int MAX_DEG   = 3;
    localparam int MAX_CP_U  = 64;
    localparam int MAX_CP_V  = 64;
    localparam int KDEPTH_U  = MAX_CP_U + MAX_DEG + 1;
    localparam int KDEPTH_V  = MAX_CP_V + MAX_DEG + 1;
    localparam int KDEPTH    = (KDEPTH_U > KDEPTH_V) ? KDEPTH_U : KDEPTH_V;
    localparam int NET_DEPTH = MAX_CP_U * MAX_CP_V;
    localparam int MAX_CP    = (MAX_CP_U > MAX_CP_V) ? MAX_CP_U : MAX_CP_V;

    localparam int KAW  = $clog2(KDEPTH);
    localparam int NAW  = $clog2(NET_DEPTH);
    localparam int BIW  = $clog2(MAX_DEG + 1);
    localparam int CPW  = $clog2(MAX_CP);
    localparam int CNTW = 7;
    localparam int DEGW = 2;
    localparam int PAW  = 4;
    localparam int PDW  = 32;

    // Weighted sums of up to sixteen Q16.16 terms stay well inside 40 bits.
    localparam int SUM_W     = 40;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 40;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [1:0] {
        OP_LOAD_U  = 2'd0,
        OP_LOAD_V  = 2'd1,
        OP_LOAD_CP = 2'd2,
        OP_EVAL    = 2'd3
    } op_t;

    localparam logic [1:0] REG_DEG_U   = 2'd0;
    localparam logic [1:0] REG_DEG_V   = 2'd1;
    localparam logic [1:0] REG_COUNT_U = 2'd2;
    localparam logic [1:0] REG_COUNT_V = 2'd3;

    typedef struct packed {
        op_t                op;
        logic [11:0]        index;
        logic signed [31:0] knot;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               bad_weight;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               sh30;
    } mul_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] val);
        logic signed [31:0] res;
        if (val > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (val < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = val[31:0];
        end
        return res;
    endfunction

endpackage

// ===== src/nspe_div.sv =====
module nspe_div (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic signed [nspe_pkg::DIV_NUM_W-1:0]     num,
    input  logic signed [nspe_pkg::DIV_DEN_W-1:0]     den,
    output logic                                      done,
    output logic signed [nspe_pkg::DIV_NUM_W-1:0]     quot
);

    localparam int NW = nspe_pkg::DIV_NUM_W;
    localparam int DW = nspe_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic                neg_reg;
    logic [NW-1:0]       nmag_reg;
    logic [DW-1:0]       dmag_reg;
    logic [DW-1:0]       rem_reg;
    logic [DW:0]         rem_sh;
    logic                ge;

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign rem_sh = {rem_reg, nmag_reg[NW-1]};
    assign ge     = (rem_sh >= {1'b0, dmag_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == CW'(1))) begin
                busy_reg <= 1'b0;
            end
        end
        if (start) begin
            cnt_reg  <= CW'(NW);
            neg_reg  <= num[NW-1] ^ den[DW-1];
            nmag_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            dmag_reg <= den[DW-1] ? DW'(-den) : DW'(den);
            rem_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CW'(1);
            nmag_reg <= {nmag_reg[NW-2:0], ge};
            rem_reg  <= ge ? DW'(rem_sh - {1'b0, dmag_reg}) : rem_sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(nmag_reg) : $signed(nmag_reg);

endmodule

// ===== src/nspe_mul.sv =====
module nspe_mul (
    input  logic               aclk,
    input  nspe_pkg::mul_req_t req,
    output logic signed [63:0] scaled
);

    logic signed [63:0] prod_reg;
    logic               sh30_reg;
    logic signed [63:0] bias;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(req.a) * 64'(req.b);
        sh30_reg <= req.sh30;
    end

    // Scale down by 2^30 or 2^16, truncating toward zero.
    always_comb begin
        bias = '0;
        if (prod_reg < 0) begin
            bias = sh30_reg ? 64'sd1073741823 : 64'sd65535;
        end
        scaled = sh30_reg ? ((prod_reg + bias) >>> 30) : ((prod_reg + bias) >>> 16);
    end

endmodule

// ===== src/nurbs_surface_point_eval_core.sv =====
// NURBS surface point evaluator. Requests with op 0, 1 and 2 load a u knot, a v knot
// or a weighted control point (x*w, y*w, z*w, w at address row*count_u+column) and
// return nothing. An evaluate request returns one point: the block searches each knot
// span one knot per cycle, runs the basis recurrence through a shared restoring
// divider and a shared 32x32 multiplier, sums the weighted control points and, for a
// nonzero weight sum, ends with three divisions by the summed weight. End parameters
// skip the recurrence. The input is not ready while an evaluate is in progress.
// A zero weight sum returns zero coordinates with bad_weight.
module nurbs_surface_point_eval_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nspe_pkg::PAW-1:0]      paddr,
    input  logic [nspe_pkg::PDW-1:0]      pwdata,
    output logic [nspe_pkg::PDW-1:0]      prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  nspe_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output nspe_pkg::out_item_t           m_data
);

    localparam int KAW   = nspe_pkg::KAW;
    localparam int NAW   = nspe_pkg::NAW;
    localparam int BIW   = nspe_pkg::BIW;
    localparam int CPW   = nspe_pkg::CPW;
    localparam int CNTW  = nspe_pkg::CNTW;
    localparam int DEGW  = nspe_pkg::DEGW;
    localparam int SUM_W = nspe_pkg::SUM_W;
    localparam int NB    = nspe_pkg::MAX_DEG + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_SIDE, S_LO, S_HI, S_SCAN, S_BINIT, S_LEFT, S_RIGHT,
        S_DSTART, S_DWAIT, S_MULR, S_MULL, S_SAVE, S_ACC, S_PT, S_BW,
        S_TERM, S_FIN, S_FDIV, S_FWAIT, S_OUT
    } state_t;

    // Configuration registers.
    logic [DEGW-1:0] deg_u_reg, deg_v_reg;
    logic [CNTW-1:0] count_u_reg, count_v_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_u_reg   <= DEGW'(3);
            deg_v_reg   <= DEGW'(3);
            count_u_reg <= CNTW'(4);
            count_v_reg <= CNTW'(4);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                nspe_pkg::REG_DEG_U:   deg_u_reg   <= pwdata[DEGW-1:0];
                nspe_pkg::REG_DEG_V:   deg_v_reg   <= pwdata[DEGW-1:0];
                nspe_pkg::REG_COUNT_U: count_u_reg <= pwdata[CNTW-1:0];
                nspe_pkg::REG_COUNT_V: count_v_reg <= pwdata[CNTW-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            nspe_pkg::REG_DEG_U:   prdata = nspe_pkg::PDW'(deg_u_reg);
            nspe_pkg::REG_DEG_V:   prdata = nspe_pkg::PDW'(deg_v_reg);
            nspe_pkg::REG_COUNT_U: prdata = nspe_pkg::PDW'(count_u_reg);
            nspe_pkg::REG_COUNT_V: prdata = nspe_pkg::PDW'(count_v_reg);
        endcase
    end

    // Effective counts and degrees at the start of an evaluate.
    logic [CNTW-1:0] eff_cu, eff_cv;
    logic [DEGW-1:0] eff_du, eff_dv;

    always_comb begin
        eff_cu = count_u_reg;
        if (count_u_reg == '0) eff_cu = CNTW'(1);
        else if (count_u_reg > CNTW'(nspe_pkg::MAX_CP_U)) eff_cu = CNTW'(nspe_pkg::MAX_CP_U);
        eff_cv = count_v_reg;
        if (count_v_reg == '0) eff_cv = CNTW'(1);
        else if (count_v_reg > CNTW'(nspe_pkg::MAX_CP_V)) eff_cv = CNTW'(nspe_pkg::MAX_CP_V);
        eff_du = deg_u_reg;
        if (CNTW'(deg_u_reg) > eff_cu - CNTW'(1)) eff_du = DEGW'(eff_cu - CNTW'(1));
        eff_dv = deg_v_reg;
        if (CNTW'(deg_v_reg) > eff_cv - CNTW'(1)) eff_dv = DEGW'(eff_cv - CNTW'(1));
    end

    // Knot and control point stores.
    logic                s_fire;
    logic [KAW-1:0]      knot_raddr;
    logic [NAW-1:0]      net_raddr;
    logic signed [31:0]  knot_u_mem [nspe_pkg::KDEPTH_U];
    logic signed [31:0]  knot_v_mem [nspe_pkg::KDEPTH_V];
    logic [127:0]        net_mem [nspe_pkg::NET_DEPTH];
    logic signed [31:0]  kq_u, kq_v;
    logic [127:0]        net_q;

    assign s_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.op == nspe_pkg::OP_LOAD_U)
            && (32'(s_data.index) < nspe_pkg::KDEPTH_U)) begin
            knot_u_mem[KAW'(s_data.index)] <= s_data.knot;
        end
        kq_u <= knot_u_mem[knot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.op == nspe_pkg::OP_LOAD_V)
            && (32'(s_data.index) < nspe_pkg::KDEPTH_V)) begin
            knot_v_mem[KAW'(s_data.index)] <= s_data.knot;
        end
        kq_v <= knot_v_mem[knot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.op == nspe_pkg::OP_LOAD_CP)
            && (32'(s_data.index) < nspe_pkg::NET_DEPTH)) begin
            net_mem[NAW'(s_data.index)] <= {s_data.cw, s_data.cz, s_data.cy, s_data.cx};
        end
        net_q <= net_mem[net_raddr];
    end

    // Shared arithmetic units.
    nspe_pkg::mul_req_t                         mul_req;
    logic signed [63:0]                         mul_out;
    logic                                       div_start;
    logic signed [nspe_pkg::DIV_NUM_W-1:0]      div_num;
    logic signed [nspe_pkg::DIV_DEN_W-1:0]      div_den;
    logic                                       div_done;
    logic signed [nspe_pkg::DIV_NUM_W-1:0]      div_quot;

    nspe_mul u_mul (
        .aclk   (aclk),
        .req    (mul_req),
        .scaled (mul_out)
    );

    nspe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer state.
    state_t              state_reg, state_next;
    logic                dir_reg, dir_next;
    logic signed [31:0]  tu_reg, tu_next, tv_reg, tv_next;
    logic [CNTW-1:0]     cu_reg, cu_next, cv_reg, cv_next;
    logic [DEGW-1:0]     du_reg, du_next, dv_reg, dv_next;
    logic [KAW-1:0]      span_reg, span_next, scan_reg, scan_next;
    logic [BIW-1:0]      j_reg, j_next, r_reg, r_next;
    logic signed [31:0]  saved_reg, saved_next, q_reg, q_next;
    logic signed [31:0]  left_reg [NB], left_next [NB];
    logic signed [31:0]  right_reg [NB], right_next [NB];
    logic signed [31:0]  bas_u_reg [NB], bas_u_next [NB];
    logic signed [31:0]  bas_v_reg [NB], bas_v_next [NB];
    logic [CPW-1:0]      base_u_reg, base_u_next, base_v_reg, base_v_next;
    logic [BIW:0]        num_u_reg, num_u_next, num_v_reg, num_v_next;
    logic [BIW-1:0]      a_reg, a_next, b_reg, b_next;
    logic signed [31:0]  bw_reg, bw_next;
    logic signed [31:0]  pt_reg [4], pt_next [4];
    logic [2:0]          k_reg, k_next;
    logic signed [SUM_W-1:0] sum_reg [4], sum_next [4];
    logic signed [31:0]  res_reg [3], res_next [3];
    logic                bad_reg, bad_next;
    logic                m_valid_reg, m_valid_next;
    nspe_pkg::out_item_t m_data_reg, m_data_next;

    // Per-direction views.
    logic signed [31:0]  cur_t, kq, n_r, sv;
    logic [DEGW-1:0]     cur_deg;
    logic [CNTW-1:0]     cur_cnt;
    logic [BIW-1:0]      jr, r1, sidx;
    logic signed [32:0]  den33;
    logic signed [SUM_W-1:0] term;
    logic                end_hit, bas_done;
    logic [CPW-1:0]      end_idx;
    logic [CPW-1:0]      row, col;
    logic [NAW:0]        net_lin;

    assign cur_t   = dir_reg ? tv_reg : tu_reg;
    assign cur_deg = dir_reg ? dv_reg : du_reg;
    assign cur_cnt = dir_reg ? cv_reg : cu_reg;
    assign kq      = dir_reg ? kq_v : kq_u;
    assign jr      = j_reg - r_reg;
    assign r1      = r_reg + BIW'(1);
    assign n_r     = dir_reg ? bas_v_reg[r_reg] : bas_u_reg[r_reg];
    assign den33   = 33'(right_reg[r1]) + 33'(left_reg[jr]);
    assign term    = mul_out[SUM_W-1:0];
    assign sidx    = BIW'(k_reg - 3'd1);
    assign sv      = nspe_pkg::sat32(mul_out);
    assign row     = base_v_reg + CPW'(a_reg);
    assign col     = base_u_reg + CPW'(b_reg);
    assign net_lin = (NAW+1)'(row) * (NAW+1)'(cu_reg) + (NAW+1)'(col);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        dir_next     = dir_reg;
        tu_next      = tu_reg;
        tv_next      = tv_reg;
        cu_next      = cu_reg;
        cv_next      = cv_reg;
        du_next      = du_reg;
        dv_next      = dv_reg;
        span_next    = span_reg;
        scan_next    = scan_reg;
        j_next       = j_reg;
        r_next       = r_reg;
        saved_next   = saved_reg;
        q_next       = q_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        bas_u_next   = bas_u_reg;
        bas_v_next   = bas_v_reg;
        base_u_next  = base_u_reg;
        base_v_next  = base_v_reg;
        num_u_next   = num_u_reg;
        num_v_next   = num_v_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        bw_next      = bw_reg;
        pt_next      = pt_reg;
        k_next       = k_reg;
        sum_next     = sum_reg;
        res_next     = res_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        knot_raddr   = '0;
        net_raddr    = '0;
        mul_req      = '0;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;
        end_hit      = 1'b0;
        end_idx      = '0;
        bas_done     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && (s_data.op == nspe_pkg::OP_EVAL)) begin
                    tu_next    = s_data.u;
                    tv_next    = s_data.v;
                    cu_next    = eff_cu;
                    cv_next    = eff_cv;
                    du_next    = eff_du;
                    dv_next    = eff_dv;
                    dir_next   = 1'b0;
                    state_next = S_SIDE;
                end
            end
            S_SIDE: begin
                if (cur_deg == '0) begin
                    end_hit = 1'b1;
                end else begin
                    knot_raddr = KAW'(cur_deg);
                    state_next = S_LO;
                end
            end
            S_LO: begin
                if (cur_t <= kq) begin
                    end_hit = 1'b1;
                end else begin
                    knot_raddr = KAW'(cur_cnt);
                    state_next = S_HI;
                end
            end
            S_HI: begin
                if (cur_t >= kq) begin
                    end_hit = 1'b1;
                    end_idx = CPW'(cur_cnt - CNTW'(1));
                end else begin
                    span_next = KAW'(cur_deg);
                    if ((CNTW'(cur_deg) + CNTW'(1)) < cur_cnt) begin
                        scan_next  = KAW'(cur_deg) + KAW'(1);
                        knot_raddr = KAW'(cur_deg) + KAW'(1);
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_BINIT;
                    end
                end
            end
            S_SCAN: begin
                if (kq <= cur_t) begin
                    span_next = scan_reg;
                end
                if ((CNTW'(scan_reg) + CNTW'(1)) < cur_cnt) begin
                    scan_next  = scan_reg + KAW'(1);
                    knot_raddr = scan_reg + KAW'(1);
                end else begin
                    state_next = S_BINIT;
                end
            end
            S_BINIT: begin
                if (dir_reg) bas_v_next[0] = nspe_pkg::ONE_Q30;
                else         bas_u_next[0] = nspe_pkg::ONE_Q30;
                j_next     = BIW'(1);
                knot_raddr = span_reg;
                state_next = S_LEFT;
            end
            S_LEFT: begin
                left_next[j_reg] = nspe_pkg::sat32(64'(cur_t) - 64'(kq));
                knot_raddr       = span_reg + KAW'(j_reg);
                state_next       = S_RIGHT;
            end
            S_RIGHT: begin
                right_next[j_reg] = nspe_pkg::sat32(64'(kq) - 64'(cur_t));
                r_next            = '0;
                saved_next        = '0;
                state_next        = S_DSTART;
            end
            S_DSTART: begin
                if (den33 == '0) begin
                    q_next     = '0;
                    state_next = S_MULR;
                end else begin
                    div_start  = 1'b1;
                    div_num    = 64'(n_r) <<< 16;
                    div_den    = nspe_pkg::DIV_DEN_W'(den33);
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (div_done) begin
                    q_next     = nspe_pkg::sat32(div_quot);
                    state_next = S_MULR;
                end
            end
            S_MULR: begin
                mul_req.a  = right_reg[r1];
                mul_req.b  = q_reg;
                state_next = S_MULL;
            end
            S_MULL: begin
                mul_req.a = left_reg[jr];
                mul_req.b = q_reg;
                if (dir_reg) bas_v_next[r_reg] = nspe_pkg::sat32(64'(saved_reg) + mul_out);
                else         bas_u_next[r_reg] = nspe_pkg::sat32(64'(saved_reg) + mul_out);
                state_next = S_SAVE;
            end
            S_SAVE: begin
                if (r1 == j_reg) begin
                    // Last product of this row becomes the new top basis value.
                    if (dir_reg) bas_v_next[j_reg] = sv;
                    else         bas_u_next[j_reg] = sv;
                    if (DEGW'(j_reg) == cur_deg) begin
                        bas_done = 1'b1;
                    end else begin
                        j_next     = j_reg + BIW'(1);
                        knot_raddr = span_reg - KAW'(j_reg);
                        state_next = S_LEFT;
                    end
                end else begin
                    saved_next = sv;
                    r_next     = r1;
                    state_next = S_DSTART;
                end
            end
            S_ACC: begin
                a_next     = '0;
                b_next     = '0;
                sum_next   = '{default: '0};
                state_next = S_PT;
            end
            S_PT: begin
                mul_req.a  = bas_v_reg[a_reg];
                mul_req.b  = bas_u_reg[b_reg];
                mul_req.sh30 = 1'b1;
                net_raddr  = net_lin[NAW-1:0];
                state_next = S_BW;
            end
            S_BW: begin
                bw_next    = sv;
                pt_next[0] = net_q[31:0];
                pt_next[1] = net_q[63:32];
                pt_next[2] = net_q[95:64];
                pt_next[3] = net_q[127:96];
                k_next     = '0;
                state_next = S_TERM;
            end
            S_TERM: begin
                if (k_reg != 3'd4) begin
                    mul_req.a    = pt_reg[k_reg[1:0]];
                    mul_req.b    = bw_reg;
                    mul_req.sh30 = 1'b1;
                    k_next       = k_reg + 3'd1;
                end
                if (k_reg != 3'd0) begin
                    sum_next[sidx] = sum_reg[sidx] + term;
                end
                if (k_reg == 3'd4) begin
                    if ((BIW+1)'(b_reg) == num_u_reg - (BIW+1)'(1)) begin
                        b_next = '0;
                        if ((BIW+1)'(a_reg) == num_v_reg - (BIW+1)'(1)) begin
                            state_next = S_FIN;
                        end else begin
                            a_next     = a_reg + BIW'(1);
                            state_next = S_PT;
                        end
                    end else begin
                        b_next     = b_reg + BIW'(1);
                        state_next = S_PT;
                    end
                end
            end
            S_FIN: begin
                k_next = '0;
                if (sum_reg[3] == '0) begin
                    res_next   = '{default: '0};
                    bad_next   = 1'b1;
                    state_next = S_OUT;
                end else begin
                    bad_next   = 1'b0;
                    state_next = S_FDIV;
                end
            end
            S_FDIV: begin
                div_start  = 1'b1;
                div_num    = 64'(sum_reg[k_reg[1:0]]) <<< 16;
                div_den    = sum_reg[3];
                state_next = S_FWAIT;
            end
            S_FWAIT: begin
                if (div_done) begin
                    res_next[k_reg[1:0]] = nspe_pkg::sat32(div_quot);
                    if (k_reg == 3'd2) begin
                        state_next = S_OUT;
                    end else begin
                        k_next     = k_reg + 3'd1;
                        state_next = S_FDIV;
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg) begin
                    m_data_next.x          = res_reg[0];
                    m_data_next.y          = res_reg[1];
                    m_data_next.z          = res_reg[2];
                    m_data_next.bad_weight = bad_reg;
                    m_valid_next           = 1'b1;
                    state_next             = S_IDLE;
                end
            end
        endcase

        // An end parameter, or degree zero, picks one row or column with full weight.
        if (end_hit) begin
            if (dir_reg) begin
                bas_v_next[0] = nspe_pkg::ONE_Q30;
                base_v_next   = end_idx;
                num_v_next    = (BIW+1)'(1);
            end else begin
                bas_u_next[0] = nspe_pkg::ONE_Q30;
                base_u_next   = end_idx;
                num_u_next    = (BIW+1)'(1);
            end
        end
        if (bas_done) begin
            if (dir_reg) begin
                base_v_next = CPW'(span_reg - KAW'(cur_deg));
                num_v_next  = (BIW+1)'(cur_deg) + (BIW+1)'(1);
            end else begin
                base_u_next = CPW'(span_reg - KAW'(cur_deg));
                num_u_next  = (BIW+1)'(cur_deg) + (BIW+1)'(1);
            end
        end
        if (end_hit || bas_done) begin
            if (dir_reg) begin
                state_next = S_ACC;
            end else begin
                dir_next   = 1'b1;
                state_next = S_SIDE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        dir_reg    <= dir_next;
        tu_reg     <= tu_next;
        tv_reg     <= tv_next;
        cu_reg     <= cu_next;
        cv_reg     <= cv_next;
        du_reg     <= du_next;
        dv_reg     <= dv_next;
        span_reg   <= span_next;
        scan_reg   <= scan_next;
        j_reg      <= j_next;
        r_reg      <= r_next;
        saved_reg  <= saved_next;
        q_reg      <= q_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        bas_u_reg  <= bas_u_next;
        bas_v_reg  <= bas_v_next;
        base_u_reg <= base_u_next;
        base_v_reg <= base_v_next;
        num_u_reg  <= num_u_next;
        num_v_reg  <= num_v_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        bw_reg     <= bw_next;
        pt_reg     <= pt_next;
        k_reg      <= k_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
        bad_reg    <= bad_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== src/nspe_checker.sv =====
module nspe_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                pready,
    input logic                s_valid,
    input logic                s_ready,
    input nspe_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input nspe_pkg::out_item_t m_data
);

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // An evaluate request occupies the block, so it cannot take the next request at once.
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op == nspe_pkg::OP_EVAL) |=> !s_ready)
        else $error("input ready right after an evaluate request");

    // A zero weight sum reports the origin.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_weight |-> (m_data.x == 0) && (m_data.y == 0) && (m_data.z == 0))
        else $error("bad weight result with nonzero coordinates");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port stalled");

endmodule

bind nurbs_surface_point_eval_core nspe_checker u_nspe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .pready  (pready),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
